[design/spjq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spjq_pkg
// shared types and constants for the sorted priority job queue
// ----------------------------------------------------------------------------
package spjq_pkg;

    localparam int unsigned ID_W        = 10;
    localparam int unsigned CNT_W       = 10;
    localparam int unsigned DEPTH_DEF   = 64;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef struct packed {
        logic             command;
        logic [ID_W-1:0]  job_id;
        logic [CNT_W-1:0] dependent_count;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0] removed_job;
        logic            queue_empty;
        logic            insert_dropped;
    } t_rsp;

    // one stored job
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [ID_W-1:0]  id;
    } t_entry;

    // operation broadcast to every cell
    typedef struct packed {
        logic   ins;
        logic   rem;
        t_entry din;
    } t_cell_op;

endpackage

[design/spjq_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spjq request and response channels
// valid/ready channels carrying a request or a response payload
// ----------------------------------------------------------------------------
interface spjq_req_if import spjq_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface spjq_rsp_if import spjq_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/sorted_priority_job_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_job_queue
// bounded job queue kept in descending dependent count order by a row of
// compare-and-shift cells; equal counts leave in arrival order
// ----------------------------------------------------------------------------
//  channel   dir  payload                                        accepted when
//  i_req     in   command, job_id, dependent_count                valid && ready
//  o_rsp     out  removed_job, queue_empty, insert_dropped        valid && ready
//
//  for every request all cells compare against the new count and move in
//  parallel, and the response is registered at the next edge
//  a new request is taken each cycle while the response register is free or
//  being drained, so a stalled sink holds at most one response
//  reset empties the queue by clearing the cell valid bits
// ----------------------------------------------------------------------------
module sorted_priority_job_queue import spjq_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    spjq_req_if.sink   i_req,
    spjq_rsp_if.source o_rsp
);

    // chain wires, one per cell
    logic   w_keep  [QUEUE_DEPTH];
    logic   w_valid [QUEUE_DEPTH];
    t_entry w_entry [QUEUE_DEPTH];

    logic     w_accept;
    logic     w_full;
    t_cell_op w_op;

    logic r_out_valid;
    t_rsp r_rsp;
    t_rsp n_rsp;

    // response register frees up when empty or drained this cycle
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    // full when the tail cell holds a job
    assign w_full = w_valid[QUEUE_DEPTH-1];

    // broadcast operation; a full insert is dropped and leaves cells alone
    assign w_op.ins = w_accept && (i_req.data.command == CMD_INSERT) && !w_full;
    assign w_op.rem = w_accept && (i_req.data.command == CMD_REMOVE);
    assign w_op.din.cnt = i_req.data.dependent_count;
    assign w_op.din.id  = i_req.data.job_id;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic   w_lkeep;
            logic   w_lvalid;
            t_entry w_lentry;
            logic   w_rvalid;
            t_entry w_rentry;

            if (g == 0) begin : g_head
                // head cell: the new job lands here unless the head ranks at or above it
                assign w_lkeep  = 1'b1;
                assign w_lvalid = 1'b0;
                assign w_lentry = w_op.din;
            end else begin : g_mid
                assign w_lkeep  = w_keep[g-1];
                assign w_lvalid = w_valid[g-1];
                assign w_lentry = w_entry[g-1];
            end

            if (g == QUEUE_DEPTH-1) begin : g_tail
                // nothing beyond the tail shifts in on a remove
                assign w_rvalid = 1'b0;
                assign w_rentry = w_op.din;
            end else begin : g_body
                assign w_rvalid = w_valid[g+1];
                assign w_rentry = w_entry[g+1];
            end

            spjq_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_op          (w_op),
                .i_left_keep   (w_lkeep),
                .i_left_valid  (w_lvalid),
                .i_left_entry  (w_lentry),
                .i_right_valid (w_rvalid),
                .i_right_entry (w_rentry),
                .o_keep        (w_keep[g]),
                .o_valid       (w_valid[g]),
                .o_entry       (w_entry[g])
            );
        end
    endgenerate

    // response for the request taken this cycle
    always_comb begin
        n_rsp = '0;
        if (i_req.data.command == CMD_REMOVE) begin
            // pop the head; empty afterwards when nothing sits behind it
            n_rsp.removed_job = w_valid[0] ? w_entry[0].id : '0;
            n_rsp.queue_empty = !w_valid[1];
        end else begin
            // an insert always leaves at least one job in the queue
            n_rsp.queue_empty    = 1'b0;
            n_rsp.insert_dropped = w_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;

endmodule

[design/spjq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spjq_cell
// one slot of the sorted chain: keeps, takes the new job, or shifts
// ----------------------------------------------------------------------------
module spjq_cell import spjq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cell_op i_op,
    input  logic     i_left_keep,
    input  logic     i_left_valid,
    input  t_entry   i_left_entry,
    input  logic     i_right_valid,
    input  t_entry   i_right_entry,
    output logic     o_keep,
    output logic     o_valid,
    output t_entry   o_entry
);

    logic   r_valid;
    t_entry r_entry;
    logic   n_valid;
    t_entry n_entry;

    // entry stays in place on insert when it ranks at or above the new one
    assign o_keep  = r_valid && (r_entry.cnt >= i_op.din.cnt);
    assign o_valid = r_valid;
    assign o_entry = r_entry;

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_op.rem) begin
            n_valid = i_right_valid;
            n_entry = i_right_entry;
        end else if (i_op.ins && !o_keep) begin
            if (i_left_keep) begin
                n_valid = 1'b1;
                n_entry = i_op.din;
            end else begin
                n_valid = i_left_valid;
                n_entry = i_left_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
